// ----- src/smh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash value, padding words and the SHA-256 mixing
// functions.
// ----------------------------------------------------------------------------
package smh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROUNDS  = 64;
    localparam int unsigned HASH_N  = 8;
    localparam int unsigned BLOCK_N = 16;

    // Padding: marker byte in the top byte of a word, and the word slot of
    // the upper length half (448 bits into the block).
    localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;
    localparam logic [3:0]  LEN_HI_SLOT   = 4'd14;
    localparam logic [3:0]  LAST_SLOT     = 4'd15;
    localparam logic [2:0]  FULL_BYTES    = 3'd4;
    localparam logic [63:0] FULL_WORD_BITS = 64'd32;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_INIT [HASH_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // Message schedule mixers
    function automatic logic [31:0] sched_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sched_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Compression mixers
    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

// ----- src/sha256_message_hasher.sv -----
// Stall: the word that fills a block is taken, then the input is held through load,
//   64 rounds and add; other words are taken while the hasher is idle.
// Throughput is set by the single round unit, which reads the block memory one word
//   per round; no new words are taken while a block is compressed.
// End of message: padding words and one or two blocks, then 8 digest items.
// Reset: asynchronous, active low; chain hash to the initial value, length zero.
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams big-endian message words into a 16-word block memory, pads the
// message at its last word, compresses each block with one round per cycle
// and emits the eight digest words as separate items.
// ----------------------------------------------------------------------------
module sha256_message_hasher
    import smh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] message_word, [34:32] bytes_valid
    input  wire logic        s_axis_tlast,   // end_of_message
    // result item
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index
    output      logic        m_axis_tlast    // digest_done
);

    typedef enum logic [2:0] {
        S_IDLE,     // take message words
        S_PAD,      // push padding and length words
        S_PRIME,    // load working registers, fetch word 0
        S_ROUND,    // one compression round per cycle
        S_UPDATE,   // add working registers into the chain hash
        S_FINISH    // hand the digest to the output register
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,    // 0x80 marker word still due
        PH_ZERO,    // zero fill up to the length slot
        PH_LO,      // lower length half due
        PH_DONE     // padding complete
    } phase_t;

    // ---------------------------------------------------------------- registers
    state_t       state_reg,    state_next;
    phase_t       phase_reg,    phase_next;
    logic [3:0]   wp_reg,       wp_next;        // next free word slot of the block
    logic [5:0]   round_reg,    round_next;
    logic [63:0]  bit_len_reg,  bit_len_next;   // message length in bits, mod 2^64
    logic         msg_end_reg,  msg_end_next;   // last word seen, padding in progress
    logic         out_busy_reg, out_busy_next;
    logic [2:0]   out_idx_reg,  out_idx_next;

    logic [31:0]  chain_reg  [HASH_N];
    logic [31:0]  chain_next [HASH_N];
    logic [31:0]  work_reg   [HASH_N];
    logic [31:0]  work_next  [HASH_N];
    logic [31:0]  sched_reg  [BLOCK_N];         // W[t-16] at index 0 .. W[t-1] at 15
    logic [31:0]  sched_next [BLOCK_N];
    logic [31:0]  w_reg,        w_next;         // precomputed W[t] for rounds 16..63
    logic [31:0]  digest_reg  [HASH_N];         // output shift line, head at index 0
    logic [31:0]  digest_next [HASH_N];

    // Block memory: written by the push path, read by the round unit. The two
    // never run in the same cycle, so no forwarding is needed.
    logic [31:0]  buf_mem [BLOCK_N];
    logic [31:0]  rd_data_reg;
    logic [3:0]   rd_addr;
    logic         push_en;
    logic [31:0]  push_word;

    // ---------------------------------------------------------------- input decode
    logic [31:0]  in_word;
    logic [2:0]   in_bytes;
    logic [2:0]   n_sat;
    logic [31:0]  final_word;
    logic         in_accept;

    assign in_word   = s_axis_tdata[31:0];
    assign in_bytes  = s_axis_tdata[34:32];
    assign n_sat     = (in_bytes > FULL_BYTES) ? FULL_BYTES : in_bytes;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Keep the valid leading bytes, put the marker byte right after them if the word has room.
    always_comb
    begin
        case (n_sat)
            3'd0:    final_word = PAD_MARK_WORD;
            3'd1:    final_word = {in_word[31:24], 24'h80_0000};
            3'd2:    final_word = {in_word[31:16], 16'h8000};
            3'd3:    final_word = {in_word[31:8], 8'h80};
            default: final_word = in_word;
        endcase
    end

    // ---------------------------------------------------------------- round datapath
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // Rounds 0..15 take the block word from memory, later rounds the
    // schedule word prepared in the previous cycle.
    assign w_cur = (round_reg[5:4] == 2'b00) ? rd_data_reg : w_reg;
    // W[t+1] from the window as it stands during round t
    assign w_new = sched_s1(sched_reg[15]) + sched_reg[10]
                 + sched_s0(sched_reg[2]) + sched_reg[1];
    assign t1 = work_reg[7] + big_s1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6])
              + ROUND_K[round_reg] + w_cur;
    assign t2 = big_s0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);

    // Fetch word 0 while priming, then one word ahead of the round count.
    assign rd_addr = (state_reg == S_PRIME) ? 4'd0 : (round_reg[3:0] + 4'd1);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        round_next    = round_reg;
        bit_len_next  = bit_len_reg;
        msg_end_next  = msg_end_reg;
        out_busy_next = out_busy_reg;
        out_idx_next  = out_idx_reg;
        chain_next    = chain_reg;
        work_next     = work_reg;
        sched_next    = sched_reg;
        w_next        = w_reg;
        digest_next   = digest_reg;
        push_en       = 1'b0;
        push_word     = '0;

        // Drain the digest one word per accepted result item.
        if (out_busy_reg && m_axis_tready)
        begin
            for (int i = 0; i < HASH_N - 1; i++)
            begin
                digest_next[i] = digest_reg[i + 1];
            end
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    push_en = 1'b1;
                    if (!s_axis_tlast)
                    begin
                        // sender must let non-final words always carry four bytes; unchecked
                        push_word    = in_word;
                        bit_len_next = bit_len_reg + FULL_WORD_BITS;
                    end
                    else
                    begin
                        push_word    = final_word;
                        bit_len_next = bit_len_reg + {58'd0, n_sat, 3'b000};
                        msg_end_next = 1'b1;
                        phase_next   = (n_sat == FULL_BYTES) ? PH_MARK : PH_ZERO;
                        state_next   = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                push_en = 1'b1;
                case (phase_reg)
                    PH_MARK:
                    begin
                        push_word  = PAD_MARK_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (wp_reg == LEN_HI_SLOT)
                        begin
                            push_word  = bit_len_reg[63:32];
                            phase_next = PH_LO;
                        end
                        else
                        begin
                            push_word = '0;
                        end
                    end
                    PH_LO:
                    begin
                        push_word  = bit_len_reg[31:0];
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        push_en    = 1'b0;
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_PRIME:
            begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = S_ROUND;
            end

            S_ROUND:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                for (int i = 0; i < BLOCK_N - 1; i++)
                begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[BLOCK_N - 1] = w_cur;
                w_next     = w_new;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                for (int i = 0; i < HASH_N; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (!msg_end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (phase_reg == PH_DONE)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end

            S_FINISH:
            begin
                // Hold until the previous digest has left the output line.
                if (!out_busy_reg)
                begin
                    digest_next   = chain_reg;
                    chain_next    = HASH_INIT;
                    bit_len_next  = '0;
                    msg_end_next  = 1'b0;
                    out_busy_next = 1'b1;
                    out_idx_next  = '0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A push into the last slot closes the block: compress it.
        if (push_en && (wp_reg == LAST_SLOT))
        begin
            state_next = S_PRIME;
        end
    end

    assign wp_next = push_en ? (wp_reg + 4'd1) : wp_reg;

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_ZERO;
            wp_reg       <= '0;
            round_reg    <= '0;
            bit_len_reg  <= '0;
            msg_end_reg  <= 1'b0;
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
            chain_reg    <= HASH_INIT;
            for (int i = 0; i < HASH_N; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            wp_reg       <= wp_next;
            round_reg    <= round_next;
            bit_len_reg  <= bit_len_next;
            msg_end_reg  <= msg_end_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg  <= out_idx_next;
            chain_reg    <= chain_next;
            work_reg     <= work_next;
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        sched_reg  <= sched_next;
        w_reg      <= w_next;
        digest_reg <= digest_next;
    end

    // ---------------------------------------------------------------- block memory
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            buf_mem[wp_reg] <= push_word;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // ---------------------------------------------------------------- ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_busy_reg;
    assign m_axis_tdata  = {5'd0, out_idx_reg, digest_reg[0]};
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

endmodule
`default_nettype wire
